// ===== sv/u8dn_pkg.sv =====
package u8dn_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned IN_DW    = 8;
  localparam int unsigned OUT_DW   = 24;
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_HYPHEN      = 21'h00002D;
  localparam logic [CP_W-1:0] CP_HYPHEN_NORM = 21'h002010;
  localparam logic [CP_W-1:0] CP_FW_MINUS    = 21'h00FF0D;
  localparam logic [CP_W-1:0] CP_MINUS_NORM  = 21'h002212;
  localparam logic [CP_W-1:0] CP_SIGN_LO     = 21'h00FFE0;
  localparam logic [CP_W-1:0] CP_SIGN_HI     = 21'h00FFE6;
  localparam logic [CP_W-1:0] CP_FW_LO       = 21'h00FF00;
  localparam logic [CP_W-1:0] CP_FW_HI       = 21'h00FF5F;
  localparam logic [CP_W-1:0] CP_FW_OFFSET   = 21'h00FEE0;

  // fullwidth currency/sign forms FFE0..FFE5
  localparam logic [CP_W-1:0] SIGN_MAP [6] = '{
    21'h0000A2, 21'h0000A3, 21'h0000AC, 21'h0000AF, 21'h0000A6, 21'h0000A5
  };

  // one decoded code point on its way from front to back
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_error;
    logic            end_of_stream;
  } raw_item_t;

endpackage

// ===== sv/u8dn_front.sv =====
module u8dn_front
  import u8dn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [IN_DW-1:0] data_byte,
  input  logic             end_of_input,
  output logic             push,
  output raw_item_t        push_item
);

  logic [1:0]      bytes_pending;
  logic [1:0]      bytes_pending_next;
  logic [CP_W-1:0] partial_value;
  logic [CP_W-1:0] partial_value_next;
  logic [CP_W-1:0] shifted;
  logic            emit;

  assign shifted = {partial_value[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    emit               = 1'b0;
    push_item          = '0;
    if (end_of_input) begin
      emit                    = 1'b1;
      push_item.end_of_stream = 1'b1;
      push_item.is_error      = (bytes_pending != 2'd0);
      push_item.code_point    = (bytes_pending != 2'd0) ? CP_REPLACEMENT : '0;
      bytes_pending_next      = 2'd0;
      partial_value_next      = '0;
    end else if (bytes_pending == 2'd0) begin
      if (!data_byte[7]) begin
        emit                 = 1'b1;
        push_item.code_point = {{(CP_W-IN_DW){1'b0}}, data_byte};
      end else if (data_byte[7:6] == 2'b10 || data_byte[7:3] == 5'b11111) begin
        emit                 = 1'b1;
        push_item.is_error   = 1'b1;
        push_item.code_point = CP_REPLACEMENT;
      end else if (data_byte[5] == 1'b0) begin
        bytes_pending_next = 2'd1;
        partial_value_next = {{(CP_W-5){1'b0}}, data_byte[4:0]};
      end else if (data_byte[4] == 1'b0) begin
        bytes_pending_next = 2'd2;
        partial_value_next = {{(CP_W-4){1'b0}}, data_byte[3:0]};
      end else begin
        bytes_pending_next = 2'd3;
        partial_value_next = {{(CP_W-3){1'b0}}, data_byte[2:0]};
      end
    end else if (data_byte[7:6] != 2'b10) begin
      // broken sequence: byte consumed, state dropped
      emit                 = 1'b1;
      push_item.is_error   = 1'b1;
      push_item.code_point = CP_REPLACEMENT;
      bytes_pending_next   = 2'd0;
      partial_value_next   = '0;
    end else begin
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        emit                 = 1'b1;
        push_item.code_point = shifted;
        partial_value_next   = '0;
      end else begin
        partial_value_next = shifted;
      end
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_value <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

// ===== sv/u8dn_queue.sv =====
module u8dn_queue
  import u8dn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  raw_item_t push_item,
  output logic      full,
  output logic      valid,
  input  logic      pop,
  output raw_item_t head
);

  raw_item_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count past depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !valid |-> !pop)
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== sv/u8dn_back.sv =====
module u8dn_back
  import u8dn_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  raw_item_t       q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_is_error,
  output logic            out_end_of_stream
);

  logic [CP_W-1:0] cp;
  logic [CP_W-1:0] cp_norm;

  assign cp = q_head.code_point;

  always_comb begin
    if (cp == CP_HYPHEN) begin
      cp_norm = CP_HYPHEN_NORM;
    end else if (cp == CP_FW_MINUS) begin
      cp_norm = CP_MINUS_NORM;
    end else if (cp >= CP_SIGN_LO && cp < CP_SIGN_HI) begin
      cp_norm = SIGN_MAP[cp[2:0]];
    end else if (cp >= CP_FW_LO && cp < CP_FW_HI) begin
      cp_norm = cp - CP_FW_OFFSET;   // fullwidth ASCII to half width
    end else begin
      cp_norm = cp;
    end
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_code_point    <= cp_norm;
      out_is_error      <= q_head.is_error;
      out_end_of_stream <= q_head.end_of_stream;
    end
  end

endmodule

// ===== sv/utf8_decode_normalize_core.sv =====
// UTF-8 decoder with code point normalization. One byte per input item
// (s_tdata[7:0]); s_tlast marks end of input and carries no byte. Each
// finished character leaves as one output item with the 21-bit code point
// in m_tdata, m_tuser set for a decoding error (code point FFFD) and m_tlast
// set on the item answering end of input. Lead bytes and middle
// continuation bytes give no output. Normalization: 2D->2010, FF0D->2212,
// FFE0-FFE5 to their Latin-1 signs, FF00-FF5E down to half width.
// No overlong or surrogate check. Throughput is one byte per cycle while
// the queue is not full, set by the combinational decode step in the front.
// A finished character is written into a queue slot at the edge that accepts
// its last byte; the output register loads it from the queue head when that
// register is empty or being read, and drives m_tvalid. The two-entry
// queue lets the front keep taking bytes while a result waits downstream.
module utf8_decode_normalize_core
  import u8dn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input bytes
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // [7:0] data_byte
  input  logic              s_tlast,   // end_of_input
  // decoded characters
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic              m_tuser,   // [0] is_error
  output logic              m_tlast    // end_of_stream
);

  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            push;
  raw_item_t       push_item;
  raw_item_t       q_head;
  logic            accept;
  logic [CP_W-1:0] code_point;

  // the front only stalls when the queue is full
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  u8dn_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata),
    .end_of_input (s_tlast),
    .push         (push),
    .push_item    (push_item)
  );

  u8dn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .head      (q_head)
  );

  // normalize and hold the result in the output register
  u8dn_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_code_point    (code_point),
    .out_is_error      (m_tuser),
    .out_end_of_stream (m_tlast)
  );

  assign m_tdata = {{(OUT_DW-CP_W){1'b0}}, code_point};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import u8dn_pkg::*;

  // one decoded character as seen on the output side
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            err;
    logic            eos;
  } decoded_t;

  // directed row: the byte, the end flag, and an optional hand-written answer
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic       typed;
    decoded_t   want;
  } row_t;

  localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no item moving
  localparam int unsigned HOLD_CYCLES  = 60;    // long receiver hold-off
  localparam int unsigned PHASE_ITEMS  = 130;

  // sender idle / receiver stall percentages per random phase
  localparam int unsigned SRC_IDLE   [4] = '{0, 85, 0, 21};
  localparam int unsigned SINK_STALL [4] = '{0, 0, 85, 21};

  // Directed table. Typed rows carry the answer that is obvious from the
  // spec; rows with typed = 0 are checked against the decoder model.
  localparam row_t DIR_ROWS [25] = '{
    '{8'h00, 1'b0, 1'b1, '{21'h000000, 1'b0, 1'b0}},      // byte zero passes
    '{8'h2D, 1'b0, 1'b1, '{21'h002010, 1'b0, 1'b0}},      // hyphen folds to 2010
    '{8'h80, 1'b0, 1'b1, '{CP_REPLACEMENT, 1'b1, 1'b0}},  // stray continuation as lead
    '{8'hFF, 1'b0, 1'b1, '{CP_REPLACEMENT, 1'b1, 1'b0}},  // FF is an invalid lead
    '{8'hEF, 1'b0, 1'b0, '0},                             // FF0D -> 2212
    '{8'hBC, 1'b0, 1'b0, '0},
    '{8'h8D, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},                             // FF01 -> half width 21
    '{8'hBC, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},                             // FFE5 -> sign table
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},                             // literal FFFD, no error
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBD, 1'b0, 1'b0, '0},
    '{8'hF7, 1'b0, 1'b0, '0},                             // largest 4-byte value
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hDF, 1'b0, 1'b0, '0},                             // bad continuation
    '{8'h41, 1'b0, 1'b1, '{CP_REPLACEMENT, 1'b1, 1'b0}},
    '{8'hE2, 1'b0, 1'b0, '0},                             // truncated end
    '{8'hA5, 1'b1, 1'b1, '{CP_REPLACEMENT, 1'b1, 1'b1}},
    '{8'hFF, 1'b1, 1'b1, '{21'h000000, 1'b0, 1'b1}}       // clean end
  };

  bit                clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata;   // [7:0] data_byte
  logic              s_tlast;   // end_of_input
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_DW-1:0] m_tdata;   // [20:0] code_point, [23:21] zero
  logic              m_tuser;   // [0] is_error
  logic              m_tlast;   // end_of_stream

  // decoder model state
  logic [1:0]      dec_pending;
  logic [CP_W-1:0] dec_accum;

  decoded_t    chars_due [$];   // characters owed by the block, oldest first
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_req;
  int unsigned hold_left;

  utf8_decode_normalize_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // half-width / sign folding of a finished code point
  function automatic logic [CP_W-1:0] fold_width(input logic [CP_W-1:0] cp);
    if (cp == 21'h00002D) return 21'h002010;
    if (cp == 21'h00FF0D) return 21'h002212;
    if (cp >= 21'h00FFE0 && cp < 21'h00FFE6) begin
      case (cp[2:0])
        3'd0:    return 21'h0000A2;
        3'd1:    return 21'h0000A3;
        3'd2:    return 21'h0000AC;
        3'd3:    return 21'h0000AF;
        3'd4:    return 21'h0000A6;
        default: return 21'h0000A5;
      endcase
    end
    if (cp >= 21'h00FF00 && cp < 21'h00FF5F) return cp - 21'h00FEE0;
    return cp;
  endfunction

  // Advances the decoder model by one item; returns 1 when a character is due.
  function automatic bit decode_byte(input logic [7:0] b, input logic eoi,
                                     output decoded_t res);
    res = '0;
    if (eoi) begin
      res.eos = 1'b1;
      if (dec_pending != 2'd0) begin
        res.cp  = CP_REPLACEMENT;
        res.err = 1'b1;
      end
      dec_pending = 2'd0;
      dec_accum   = '0;
      return 1'b1;
    end
    if (dec_pending == 2'd0) begin
      if (!b[7]) begin
        res.cp = fold_width({13'd0, b});
        return 1'b1;
      end
      // 80-BF or F8-FF cannot open a sequence
      if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
        res.cp  = CP_REPLACEMENT;
        res.err = 1'b1;
        return 1'b1;
      end
      if (!b[5]) begin
        dec_pending = 2'd1;
        dec_accum   = {16'd0, b[4:0]};
      end else if (!b[4]) begin
        dec_pending = 2'd2;
        dec_accum   = {17'd0, b[3:0]};
      end else begin
        dec_pending = 2'd3;
        dec_accum   = {18'd0, b[2:0]};
      end
      return 1'b0;
    end
    // open sequence: anything but 10xxxxxx is consumed as an error
    if (b[7:6] != 2'b10) begin
      dec_pending = 2'd0;
      dec_accum   = '0;
      res.cp      = CP_REPLACEMENT;
      res.err     = 1'b1;
      return 1'b1;
    end
    dec_accum   = {dec_accum[CP_W-7:0], b[5:0]};
    dec_pending = dec_pending - 2'd1;
    if (dec_pending != 2'd0) return 1'b0;
    res.cp    = fold_width(dec_accum);
    dec_accum = '0;
    return 1'b1;
  endfunction

  // Offers one item, starting and ending at a falling edge. Valid is only
  // dropped inside an idle gap, so it never toggles twice in one step.
  task automatic send_item(input logic [7:0] b, input logic eoi, input logic typed,
                           input decoded_t typed_res);
    decoded_t res;
    bit       made;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eoi;
    do @(posedge clk); while (!s_tready);
    made = decode_byte(b, eoi, res);
    if (typed) chars_due.push_back(typed_res);
    else if (made) chars_due.push_back(res);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(b, 1'b0, 1'b0, '0);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // lead byte for a sequence with n continuation bytes
  function automatic logic [7:0] lead_byte(input int unsigned n);
    case (n)
      1:       return 8'hC0 | 8'($urandom_range(31));
      2:       return 8'hE0 | 8'($urandom_range(15));
      default: return 8'hF0 | 8'($urandom_range(7));
    endcase
  endfunction

  // any byte that is not 10xxxxxx
  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b[7:6] == 2'b10) b[6] = 1'b1;
    return b;
  endfunction

  // Mostly well-formed characters, with broken sequences, noise and ends mixed in.
  task automatic send_random_char();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 28) begin
      send_data((pick < 4) ? 8'h2D : 8'($urandom_range(127)));
    end else if (pick < 42) begin
      send_data(lead_byte(1));
      send_data(cont_byte());
    end else if (pick < 56) begin
      send_data(lead_byte(2));
      repeat (2) send_data(cont_byte());
    end else if (pick < 68) begin
      // the folded region around FFxx
      send_data(8'hEF);
      case ($urandom_range(3))
        0: begin
          send_data(8'hBC);
          send_data(cont_byte());                        // FF00-FF3F
        end
        1: begin
          send_data(8'hBD);
          send_data(8'h80 | 8'($urandom_range(31)));     // FF40-FF5F, top edge
        end
        2: begin
          send_data(8'hBF);
          send_data(8'hA0 | 8'($urandom_range(7)));      // FFE0-FFE7, both edges
        end
        default: begin
          send_data(8'hBF);
          send_data(8'hBD);                              // encoded FFFD
        end
      endcase
    end else if (pick < 78) begin
      send_data(lead_byte(3));
      repeat (3) send_data(cont_byte());
    end else if (pick < 88) begin
      n = $urandom_range(3, 1);
      send_data(lead_byte(n));
      repeat ($urandom_range(n - 1, 0)) send_data(cont_byte());
      send_data(stray_byte());
    end else if (pick < 95) begin
      send_data(8'($urandom));
    end else begin
      // end of input, half the time cutting a sequence short
      if ($urandom_range(1) == 1) begin
        n = $urandom_range(3, 1);
        send_data(lead_byte(n));
        repeat ($urandom_range(n - 1, 0)) send_data(cont_byte());
      end
      send_item(8'($urandom), 1'b1, 1'b0, '0);
    end
  endtask

  // sender pause until every owed character has come out
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (chars_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Receiver: random stalls, plus a counted hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Output check against the oldest owed character.
  always @(posedge clk) begin
    decoded_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (chars_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected item cp=%h err=%b eos=%b",
                                m_tdata[CP_W-1:0], m_tuser, m_tlast));
      end else begin
        want = chars_due.pop_front();
        if (m_tdata[CP_W-1:0] !== want.cp)
          flag_mismatch($sformatf("code_point got %h want %h", m_tdata[CP_W-1:0], want.cp));
        if (m_tuser !== want.err)
          flag_mismatch($sformatf("is_error got %b want %b (cp %h)", m_tuser, want.err,
                                  want.cp));
        if (m_tlast !== want.eos)
          flag_mismatch($sformatf("end_of_stream got %b want %b (cp %h)", m_tlast, want.eos,
                                  want.cp));
      end
    end
  end

  // Watchdog: too long with no item moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stop_at;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    m_tready       = 1'b0;
    dec_pending    = 2'd0;
    dec_accum      = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed rows, back to back
    for (int i = 0; i < 25; i++)
      send_item(DIR_ROWS[i].b, DIR_ROWS[i].eoi, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    wait_quiet();

    // random phases with different idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      stop_at        = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < stop_at) send_random_char();
      wait_quiet();
    end

    // backpressure: receiver holds off while the sender keeps pushing,
    // so the queue fills and s_tready must drop
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (30) send_data(8'($urandom_range(127)));
    repeat (6) send_random_char();
    wait_quiet();

    // tail: allow for anything still draining out of the pipeline
    repeat (10) @(negedge clk);
    if (chars_due.size() != 0)
      flag_mismatch($sformatf("%0d characters never came out", chars_due.size()));
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
